/* rtl/core/dfpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpa_pkg
// Shared types, constants and helpers for the decimal fixed-point ALU.
// ----------------------------------------------------------------------------
package dfpa_pkg;

    localparam int FRAC_DIGITS_DEF = 4;
    localparam int INT_W           = 16;
    localparam int FRAC_W          = 15;
    localparam int CMD_W           = 3;
    localparam int ST_W            = 2;
    localparam int INT_MAX_MAG     = 32767;
    localparam int QUEUE_DEPTH     = 4;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EQ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_GT  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LT  = 3'd6;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
    localparam logic [ST_W-1:0] ST_DIV0 = 2'd2;

    // operation class decided by the front end
    typedef enum logic [2:0] {
        OP_ADDSUB,
        OP_MUL,
        OP_DIV,
        OP_DIVZ,
        OP_CMP,
        OP_NONE
    } op_class_t;

    // 10^n
    function automatic longint unsigned pow10(input int n);
        longint unsigned s;
        s = 1;
        for (int i = 0; i < n; i++) begin
            s = s * 10;
        end
        return s;
    endfunction

    // bits needed for a value
    function automatic int bits_for(input longint unsigned v);
        int b;
        b = 1;
        while ((v >> b) != 0) begin
            b++;
        end
        return b;
    endfunction

endpackage

/* rtl/core/dfpa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpa_front
// Accepts transactions, folds operands into scaled values and classifies them.
// Resolves add, subtract and compares into one registered descriptor.
// ----------------------------------------------------------------------------
module dfpa_front #(
    parameter int FRAC_DIGITS = dfpa_pkg::FRAC_DIGITS_DEF,
    parameter int VW          = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [dfpa_pkg::CMD_W-1:0]        cmd,
    input  logic signed [dfpa_pkg::INT_W-1:0] a_int,
    input  logic signed [dfpa_pkg::FRAC_W-1:0] a_frac,
    input  logic signed [dfpa_pkg::INT_W-1:0] b_int,
    input  logic signed [dfpa_pkg::FRAC_W-1:0] b_frac,
    output logic                              d_valid,
    output dfpa_pkg::op_class_t               d_op,
    output logic                              d_neg,
    output logic [VW-1:0]                     d_am,
    output logic [VW-1:0]                     d_bm,
    output logic                              d_cmp
);

    localparam longint unsigned SCALE = dfpa_pkg::pow10(FRAC_DIGITS);

    logic signed [VW-1:0] a_v, b_v, r_v;
    logic                 valid_reg;
    dfpa_pkg::op_class_t  op_reg, op_next;
    logic                 neg_reg, neg_next, cmp_reg, cmp_next;
    logic [VW-1:0]        am_reg, am_next, bm_reg, bm_next;

    // scaled operands
    assign a_v = VW'(a_int) * $signed(VW'(SCALE)) + VW'(a_frac);
    assign b_v = VW'(b_int) * $signed(VW'(SCALE)) + VW'(b_frac);

    // classify
    always_comb
    begin
        r_v      = (cmd == dfpa_pkg::CMD_SUB) ? a_v - b_v : a_v + b_v;
        op_next  = dfpa_pkg::OP_NONE;
        cmp_next = 1'b0;
        neg_next = (a_v < 0) != (b_v < 0);
        am_next  = a_v < 0 ? -a_v : a_v;
        bm_next  = b_v < 0 ? -b_v : b_v;
        unique case (cmd)
            dfpa_pkg::CMD_ADD, dfpa_pkg::CMD_SUB:
            begin
                op_next  = dfpa_pkg::OP_ADDSUB;
                neg_next = r_v < 0;
                am_next  = r_v < 0 ? -r_v : r_v;
            end
            dfpa_pkg::CMD_MUL: op_next = dfpa_pkg::OP_MUL;
            dfpa_pkg::CMD_DIV:
                op_next = (b_v == 0) ? dfpa_pkg::OP_DIVZ : dfpa_pkg::OP_DIV;
            dfpa_pkg::CMD_EQ:
            begin
                op_next  = dfpa_pkg::OP_CMP;
                cmp_next = a_v == b_v;
            end
            dfpa_pkg::CMD_GT:
            begin
                op_next  = dfpa_pkg::OP_CMP;
                cmp_next = a_v > b_v;
            end
            dfpa_pkg::CMD_LT:
            begin
                op_next  = dfpa_pkg::OP_CMP;
                cmp_next = a_v < b_v;
            end
            default: op_next = dfpa_pkg::OP_NONE;
        endcase
    end

    // valid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // descriptor register
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        cmp_reg <= cmp_next;
        am_reg  <= am_next;
        bm_reg  <= bm_next;
    end

    assign d_valid = valid_reg;
    assign d_op    = op_reg;
    assign d_neg   = neg_reg;
    assign d_am    = am_reg;
    assign d_bm    = bm_reg;
    assign d_cmp   = cmp_reg;

endmodule

/* rtl/core/dfpa_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpa_queue
// Short FIFO of classified descriptors between front end and back end.
// ----------------------------------------------------------------------------
module dfpa_queue #(
    parameter int W     = 8,
    parameter int DEPTH = dfpa_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty,
    output logic         full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    // pointer and count control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rp_reg];
    assign empty   = cnt_reg == '0;
    assign full    = cnt_reg == (AW+1)'(DEPTH);

endmodule

/* rtl/core/dfpa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpa_back
// Executes descriptors: pipelined multiply, radix-2 pipelined restoring
// divider, then saturation and split into integer part and fraction.
// ----------------------------------------------------------------------------
module dfpa_back #(
    parameter int FRAC_DIGITS = dfpa_pkg::FRAC_DIGITS_DEF,
    parameter int VW          = 40
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               d_valid,
    input  dfpa_pkg::op_class_t                d_op,
    input  logic                               d_neg,
    input  logic [VW-1:0]                      d_am,
    input  logic [VW-1:0]                      d_bm,
    input  logic                               d_cmp,
    output logic                               r_valid,
    output logic signed [dfpa_pkg::INT_W-1:0]  r_int,
    output logic signed [dfpa_pkg::FRAC_W-1:0] r_frac,
    output logic                               cmp_true,
    output logic [dfpa_pkg::ST_W-1:0]          status
);

    localparam longint unsigned SCALE  = dfpa_pkg::pow10(FRAC_DIGITS);
    localparam longint unsigned MAXMAG =
        longint'(dfpa_pkg::INT_MAX_MAG) * SCALE + (SCALE - 1);
    localparam int SW = dfpa_pkg::bits_for(SCALE);
    localparam int QW = dfpa_pkg::bits_for(longint'(dfpa_pkg::INT_MAX_MAG) + 1);
    // dividend am*SCALE bits and the stage count of the divider
    localparam int NW = VW + SW;
    localparam int NS = NW;
    localparam int MW = 2 * VW;
    // reciprocal of the scale: exact quotient for any XW-bit input
    localparam int XW  = (VW > 2 * SW) ? VW : 2 * SW;
    localparam int RSH = XW + SW;
    localparam int PW  = 2 * XW + 2;
    localparam longint unsigned RECIP = ((64'd1 << RSH) + SCALE - 1) / SCALE;

    // quotient by the scale constant through the reciprocal
    function automatic logic [XW-1:0] div_scale(input logic [XW-1:0] x);
        logic [PW-1:0] p;
        p = PW'(x) * PW'(RECIP);
        return XW'(p >> RSH);
    endfunction

    // ---------------- stage 1: quotient by the scale ----------------
    typedef struct packed {
        logic                op_v;
        dfpa_pkg::op_class_t op;
        logic                neg;
        logic                cmp;
    } tag_t;

    tag_t          t1_reg;
    logic          v1_reg;
    logic [VW-1:0] am1_reg, bm1_reg;
    logic [VW-1:0] aq1_reg, bq1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        t1_reg  <= '{op_v: 1'b1, op: d_op, neg: d_neg, cmp: d_cmp};
        am1_reg <= d_am;
        bm1_reg <= d_bm;
        aq1_reg <= VW'(div_scale(XW'(d_am)));
        bq1_reg <= VW'(div_scale(XW'(d_bm)));
    end

    // ---------------- stage 1b: remainder by the scale ----------------
    tag_t          t1b_reg;
    logic          v1b_reg;
    logic [VW-1:0] am1b_reg, bm1b_reg;
    logic [VW-1:0] aq1b_reg, ar1b_reg, bq1b_reg, br1b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1b_reg <= 1'b0;
        else
            v1b_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        t1b_reg  <= t1_reg;
        am1b_reg <= am1_reg;
        bm1b_reg <= bm1_reg;
        aq1b_reg <= aq1_reg;
        bq1b_reg <= bq1_reg;
        ar1b_reg <= am1_reg - aq1_reg * VW'(SCALE);
        br1b_reg <= bm1_reg - bq1_reg * VW'(SCALE);
    end

    // ---------------- stage 2: partial products ----------------
    tag_t          t2_reg;
    logic          v2_reg;
    logic [VW-1:0] am2_reg, bm2_reg;
    logic [MW-1:0] pqq_reg, pqr_reg, prq_reg, prr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1b_reg;
    end

    always_ff @(posedge clk)
    begin
        t2_reg  <= t1b_reg;
        am2_reg <= am1b_reg;
        bm2_reg <= bm1b_reg;
        pqq_reg <= MW'(aq1b_reg[QW-1:0] * bq1b_reg[QW-1:0]);
        pqr_reg <= MW'(aq1b_reg[QW-1:0] * br1b_reg[SW-1:0]);
        prq_reg <= MW'(ar1b_reg[SW-1:0] * bq1b_reg[QW-1:0]);
        prr_reg <= MW'(ar1b_reg[SW-1:0] * br1b_reg[SW-1:0]);
    end

    // ---------------- stage 3: combine product, scale dividend ----------------
    tag_t          t3_reg;
    logic          v3_reg;
    logic [MW-1:0] m3_reg, mq3_reg;
    logic [NW-1:0] num3_reg;
    logic [VW-1:0] den3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    // add and subtract carry their magnitude in place of the product
    always_ff @(posedge clk)
    begin
        t3_reg   <= t2_reg;
        if (t2_reg.op == dfpa_pkg::OP_ADDSUB)
        begin
            m3_reg  <= MW'(am2_reg);
            mq3_reg <= '0;
        end
        else
        begin
            m3_reg  <= MW'(pqq_reg * MW'(SCALE)) + pqr_reg + prq_reg;
            mq3_reg <= MW'(div_scale(XW'(prr_reg)));
        end
        num3_reg <= NW'(am2_reg) * NW'(SCALE);
        den3_reg <= bm2_reg;
    end

    // ---------------- divider stages, one quotient bit each ----------------
    tag_t          tdv_reg  [NS+1];
    logic          vdv_reg  [NS+1];
    logic [NW-1:0] rem_reg  [NS+1];
    logic [NW-1:0] quo_reg  [NS+1];
    logic [VW-1:0] den_reg  [NS+1];
    logic [MW-1:0] mm_reg   [NS+1];

    always_comb
    begin
        tdv_reg[0] = t3_reg;
        vdv_reg[0] = v3_reg;
        rem_reg[0] = '0;
        quo_reg[0] = num3_reg;
        den_reg[0] = den3_reg;
        mm_reg[0]  = m3_reg + mq3_reg;
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_div
        logic [NW:0] trial;
        logic [NW:0] shifted;
        assign shifted = {rem_reg[g], quo_reg[g][NW-1]};
        assign trial   = shifted - (NW+1)'(den_reg[g]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vdv_reg[g+1] <= 1'b0;
            else
                vdv_reg[g+1] <= vdv_reg[g];
        end

        always_ff @(posedge clk)
        begin
            tdv_reg[g+1] <= tdv_reg[g];
            den_reg[g+1] <= den_reg[g];
            mm_reg[g+1]  <= mm_reg[g];
            if (!trial[NW])
            begin
                rem_reg[g+1] <= trial[NW-1:0];
                quo_reg[g+1] <= {quo_reg[g][NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[g+1] <= shifted[NW-1:0];
                quo_reg[g+1] <= {quo_reg[g][NW-2:0], 1'b0};
            end
        end
    end

    // ---------------- select and saturate ----------------
    tag_t          t5_reg, t5_next;
    logic          v5_reg;
    logic [VW-1:0] mag5_reg;
    logic          ovf5_reg;
    logic [MW-1:0] sel_mag;

    always_comb
    begin
        unique case (tdv_reg[NS].op)
            dfpa_pkg::OP_MUL:    sel_mag = mm_reg[NS];
            dfpa_pkg::OP_DIV:    sel_mag = MW'(quo_reg[NS]);
            dfpa_pkg::OP_ADDSUB: sel_mag = MW'(mm_reg[NS]);
            default:             sel_mag = '0;
        endcase
    end

    // a zero product or quotient carries no sign
    always_comb
    begin
        t5_next = tdv_reg[NS];
        if ((tdv_reg[NS].op == dfpa_pkg::OP_MUL || tdv_reg[NS].op == dfpa_pkg::OP_DIV)
            && sel_mag == '0)
            t5_next.neg = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= vdv_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        t5_reg   <= t5_next;
        ovf5_reg <= sel_mag > MW'(MAXMAG);
        mag5_reg <= (sel_mag > MW'(MAXMAG)) ? VW'(MAXMAG) : VW'(sel_mag);
    end

    // ---------------- integer part ----------------
    tag_t          t6_reg;
    logic          v6_reg;
    logic [VW-1:0] mag6_reg, ip6_reg;
    logic          ovf6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        t6_reg   <= t5_reg;
        mag6_reg <= mag5_reg;
        ovf6_reg <= ovf5_reg;
        ip6_reg  <= VW'(div_scale(XW'(mag5_reg)));
    end

    // ---------------- split into output fields ----------------
    logic                              v7_reg;
    logic signed [dfpa_pkg::INT_W-1:0]  ri_reg;
    logic signed [dfpa_pkg::FRAC_W-1:0] rf_reg;
    logic                              cmp_reg;
    logic [dfpa_pkg::ST_W-1:0]          st_reg;
    logic [VW-1:0]                     ip, fp;
    logic                              arith;

    assign ip    = ip6_reg;
    assign fp    = mag6_reg - ip6_reg * VW'(SCALE);
    assign arith = t6_reg.op == dfpa_pkg::OP_ADDSUB || t6_reg.op == dfpa_pkg::OP_MUL
                   || t6_reg.op == dfpa_pkg::OP_DIV;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        ri_reg  <= '0;
        rf_reg  <= '0;
        cmp_reg <= (t6_reg.op == dfpa_pkg::OP_CMP) ? t6_reg.cmp : 1'b0;
        st_reg  <= dfpa_pkg::ST_OK;
        if (arith)
        begin
            ri_reg <= t6_reg.neg ? -ip[dfpa_pkg::INT_W-1:0] : ip[dfpa_pkg::INT_W-1:0];
            rf_reg <= t6_reg.neg ? -fp[dfpa_pkg::FRAC_W-1:0] : fp[dfpa_pkg::FRAC_W-1:0];
            st_reg <= ovf6_reg ? dfpa_pkg::ST_OVF : dfpa_pkg::ST_OK;
        end
        else if (t6_reg.op == dfpa_pkg::OP_DIVZ)
            st_reg <= dfpa_pkg::ST_DIV0;
    end

    assign r_valid  = v7_reg;
    assign r_int    = ri_reg;
    assign r_frac   = rf_reg;
    assign cmp_true = cmp_reg;
    assign status   = st_reg;

    // assertions
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && status == dfpa_pkg::ST_OVF |->
            (r_int == 16'sd32767 || r_int == -16'sd32767))
        else $error("overflow without saturated integer part");
    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && status == dfpa_pkg::ST_DIV0 |-> r_int == 0 && r_frac == 0)
        else $error("divide by zero with nonzero result");
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && cmp_true |-> r_int == 0 && r_frac == 0 && status == dfpa_pkg::ST_OK)
        else $error("compare result with arithmetic fields set");

endmodule

/* rtl/core/decimal_fixed_point_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_fixed_point_alu
// Add, subtract, multiply, divide and compare on decimal fixed-point values.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  command   | start / busy       | cmd, a_int, a_frac, b_int, b_frac
//  result    | done (one cycle)   | r_int, r_frac, cmp_true, status
//
//  One transaction per cycle while busy is low, sustained; every transaction
//  runs the same fixed pipeline (front register, queue, quotient by scale,
//  remainder, partial products, combine, one divider stage per quotient bit,
//  saturate, integer part, fraction), so latency is fixed by divider depth.
//  Reset clears all valid bits and the queue.
//  The receiver cannot stall; busy stays low in normal use.
// ----------------------------------------------------------------------------
module decimal_fixed_point_alu #(
    parameter int FRAC_DIGITS = dfpa_pkg::FRAC_DIGITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [dfpa_pkg::CMD_W-1:0]         cmd,
    input  logic signed [dfpa_pkg::INT_W-1:0]  a_int,
    input  logic signed [dfpa_pkg::FRAC_W-1:0] a_frac,
    input  logic signed [dfpa_pkg::INT_W-1:0]  b_int,
    input  logic signed [dfpa_pkg::FRAC_W-1:0] b_frac,
    output logic                               done,
    output logic signed [dfpa_pkg::INT_W-1:0]  r_int,
    output logic signed [dfpa_pkg::FRAC_W-1:0] r_frac,
    output logic                               cmp_true,
    output logic [dfpa_pkg::ST_W-1:0]          status
);

    localparam int VW = dfpa_pkg::bits_for(
        2 * (longint'(32768) * dfpa_pkg::pow10(FRAC_DIGITS) + 32768)) + 1;
    localparam int QW = 3 + 1 + 1 + 2 * VW;

    logic                d_valid, d_neg, d_cmp;
    dfpa_pkg::op_class_t d_op;
    logic [VW-1:0]       d_am, d_bm;
    logic [QW-1:0]       q_wdata, q_rdata;
    logic                q_empty, q_full, q_rd;

    // front end: accept and classify
    dfpa_front #(.FRAC_DIGITS(FRAC_DIGITS), .VW(VW)) u_front (
        .clk, .rst_n,
        .in_valid(start && !busy),
        .cmd, .a_int, .a_frac, .b_int, .b_frac,
        .d_valid, .d_op, .d_neg, .d_am, .d_bm, .d_cmp
    );

    assign q_wdata = {d_op, d_neg, d_cmp, d_am, d_bm};
    assign q_rd    = !q_empty;
    assign busy    = q_full;

    // decoupling queue
    dfpa_queue #(.W(QW)) u_queue (
        .clk, .rst_n,
        .wr_en(d_valid), .wr_data(q_wdata),
        .rd_en(q_rd), .rd_data(q_rdata),
        .empty(q_empty), .full(q_full)
    );

    // back end: execute
    dfpa_back #(.FRAC_DIGITS(FRAC_DIGITS), .VW(VW)) u_back (
        .clk, .rst_n,
        .d_valid(q_rd),
        .d_op(dfpa_pkg::op_class_t'(q_rdata[QW-1 -: 3])),
        .d_neg(q_rdata[2*VW+1]),
        .d_cmp(q_rdata[2*VW]),
        .d_am(q_rdata[2*VW-1:VW]),
        .d_bm(q_rdata[VW-1:0]),
        .r_valid(done), .r_int, .r_frac, .cmp_true, .status
    );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimal fixed-point ALU. Drives random and
// corner-case operations through the start/busy port with random gaps,
// predicts each result from scaled operand values and checks it against
// the done strobe in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [dfpa_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam longint SCALE      = 10000;
    localparam int     WDOG_LIMIT = 5000;
    localparam int     N_RANDOM   = 2000;

    typedef struct {
        logic signed [dfpa_pkg::INT_W-1:0]  r_int;
        logic signed [dfpa_pkg::FRAC_W-1:0] r_frac;
        logic                               cmp_true;
        logic [dfpa_pkg::ST_W-1:0]          status;
    } alu_result_t;

    // split a sign and magnitude into result fields, clamping on overflow
    function automatic alu_result_t split_result(bit neg, longint unsigned mag,
                                                 logic [dfpa_pkg::ST_W-1:0] st);
        alu_result_t r;
        longint unsigned maxmag, ip, fp;
        maxmag = dfpa_pkg::INT_MAX_MAG * SCALE + (SCALE - 1);
        if (mag > maxmag)
        begin
            mag = maxmag;
            st  = dfpa_pkg::ST_OVF;
        end
        ip = mag / SCALE;
        fp = mag % SCALE;
        if (neg)
        begin
            ip = -ip;
            fp = -fp;
        end
        r.r_int    = ip[dfpa_pkg::INT_W-1:0];
        r.r_frac   = fp[dfpa_pkg::FRAC_W-1:0];
        r.cmp_true = 1'b0;
        r.status   = st;
        return r;
    endfunction

    // expected ALU result for one operation
    function automatic alu_result_t alu_predict(logic [dfpa_pkg::CMD_W-1:0] op,
            logic signed [dfpa_pkg::INT_W-1:0] ai, logic signed [dfpa_pkg::FRAC_W-1:0] af,
            logic signed [dfpa_pkg::INT_W-1:0] bi, logic signed [dfpa_pkg::FRAC_W-1:0] bf);
        alu_result_t r;
        longint a, b, s;
        longint unsigned am, bm, m;
        bit neg;
        a   = longint'(ai) * SCALE + longint'(af);
        b   = longint'(bi) * SCALE + longint'(bf);
        am  = (a < 0) ? -a : a;
        bm  = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        r   = '{0, 0, 1'b0, dfpa_pkg::ST_OK};
        case (op)
            dfpa_pkg::CMD_ADD:
            begin
                s = a + b;
                r = split_result(s < 0, (s < 0) ? -s : s, dfpa_pkg::ST_OK);
            end
            dfpa_pkg::CMD_SUB:
            begin
                s = a - b;
                r = split_result(s < 0, (s < 0) ? -s : s, dfpa_pkg::ST_OK);
            end
            dfpa_pkg::CMD_MUL:
            begin
                m = (am * bm) / SCALE;
                r = split_result(neg && m != 0, m, dfpa_pkg::ST_OK);
            end
            dfpa_pkg::CMD_DIV:
            begin
                if (bm == 0)
                    r.status = dfpa_pkg::ST_DIV0;
                else
                begin
                    m = (am * SCALE) / bm;
                    r = split_result(neg && m != 0, m, dfpa_pkg::ST_OK);
                end
            end
            dfpa_pkg::CMD_EQ: r.cmp_true = (a == b);
            dfpa_pkg::CMD_GT: r.cmp_true = (a > b);
            dfpa_pkg::CMD_LT: r.cmp_true = (a < b);
            default: ;
        endcase
        return r;
    endfunction

    // in-order store of predicted results
    class alu_scoreboard;
        alu_result_t pending_q[$];
        int          errors;

        function void note_command(logic [dfpa_pkg::CMD_W-1:0] op,
                logic signed [dfpa_pkg::INT_W-1:0] ai,
                logic signed [dfpa_pkg::FRAC_W-1:0] af,
                logic signed [dfpa_pkg::INT_W-1:0] bi,
                logic signed [dfpa_pkg::FRAC_W-1:0] bf);
            pending_q.push_back(alu_predict(op, ai, af, bi, bf));
        endfunction

        function void check_result(alu_result_t got);
            alu_result_t exp_r;
            if (pending_q.size() == 0)
            begin
                $error("result with no pending transaction");
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.r_int !== exp_r.r_int)
            begin
                $error("r_int exp %0d got %0d", exp_r.r_int, got.r_int);
                errors++;
            end
            if (got.r_frac !== exp_r.r_frac)
            begin
                $error("r_frac exp %0d got %0d", exp_r.r_frac, got.r_frac);
                errors++;
            end
            if (got.cmp_true !== exp_r.cmp_true)
            begin
                $error("cmp_true exp %0b got %0b", exp_r.cmp_true, got.cmp_true);
                errors++;
            end
            if (got.status !== exp_r.status)
            begin
                $error("status exp %0d got %0d", exp_r.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [dfpa_pkg::CMD_W-1:0]         cmd;
    logic signed [dfpa_pkg::INT_W-1:0]  a_int;
    logic signed [dfpa_pkg::FRAC_W-1:0] a_frac;
    logic signed [dfpa_pkg::INT_W-1:0]  b_int;
    logic signed [dfpa_pkg::FRAC_W-1:0] b_frac;
    logic                               done;
    logic signed [dfpa_pkg::INT_W-1:0]  r_int;
    logic signed [dfpa_pkg::FRAC_W-1:0] r_frac;
    logic                               cmp_true;
    logic [dfpa_pkg::ST_W-1:0]          status;

    alu_scoreboard sb = new();
    int            idle_cycles = 0;

    decimal_fixed_point_alu dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .a_int    (a_int),
        .a_frac   (a_frac),
        .b_int    (b_int),
        .b_frac   (b_frac),
        .done     (done),
        .r_int    (r_int),
        .r_frac   (r_frac),
        .cmp_true (cmp_true),
        .status   (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result('{r_int, r_frac, cmp_true, status});
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // one transaction; called at a falling edge, returns at a falling edge
    task automatic send_op(logic [dfpa_pkg::CMD_W-1:0] op,
            logic signed [dfpa_pkg::INT_W-1:0] ai,
            logic signed [dfpa_pkg::FRAC_W-1:0] af,
            logic signed [dfpa_pkg::INT_W-1:0] bi,
            logic signed [dfpa_pkg::FRAC_W-1:0] bf, int gap);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd    = op;
        a_int  = ai;
        a_frac = af;
        b_int  = bi;
        b_frac = bf;
        start  = 1'b1;
        do @(posedge clk); while (busy);
        sb.note_command(op, ai, af, bi, bf);
        @(negedge clk);
    endtask

    // operand: full-width noise, well-formed, small, or extreme
    task automatic pick_operand(output logic signed [dfpa_pkg::INT_W-1:0] ip,
                                output logic signed [dfpa_pkg::FRAC_W-1:0] fp);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
        begin
            ip = dfpa_pkg::INT_W'($urandom);
            fp = dfpa_pkg::FRAC_W'($urandom);
        end
        else if (sel < 6)
        begin
            ip = dfpa_pkg::INT_W'($urandom_range(0, 32767));
            fp = dfpa_pkg::FRAC_W'($urandom_range(0, 9999));
            if ($urandom_range(0, 1))
            begin
                ip = -ip;
                fp = -fp;
            end
        end
        else if (sel < 9)
        begin
            ip = dfpa_pkg::INT_W'($urandom_range(0, 20));
            fp = dfpa_pkg::FRAC_W'($urandom_range(0, 9999));
            if ($urandom_range(0, 1))
            begin
                ip = -ip;
                fp = -fp;
            end
        end
        else
        begin
            ip = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32767;
            fp = $urandom_range(0, 1) ? 15'sd9999 : 15'sd0;
            if (ip < 0)
                fp = -fp;
        end
    endtask

    // stimulus
    initial
    begin
        logic signed [dfpa_pkg::INT_W-1:0]  ai, bi;
        logic signed [dfpa_pkg::FRAC_W-1:0] af, bf;
        logic [dfpa_pkg::CMD_W-1:0]         op;
        int                                 gap;
        rst_n  = 1'b0;
        start  = 1'b0;
        cmd    = dfpa_pkg::CMD_ADD;
        a_int  = '0;
        a_frac = '0;
        b_int  = '0;
        b_frac = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner cases: extremes, overflow, mixed signs, wide fractions
        send_op(dfpa_pkg::CMD_ADD, 16'sd32767, 15'sd9999, 16'sd32767, 15'sd9999, 0);
        send_op(dfpa_pkg::CMD_SUB, -16'sd32767, -15'sd9999, 16'sd32767, 15'sd9999, 0);
        send_op(dfpa_pkg::CMD_ADD, 16'sd1, 15'sd5000, -16'sd1, -15'sd5000, 0);
        send_op(dfpa_pkg::CMD_SUB, 16'sd3, -15'sd2500, 16'sd0, 15'sd16383, 2);
        send_op(dfpa_pkg::CMD_MUL, 16'sd32767, 15'sd9999, -16'sd32767, -15'sd9999, 0);
        send_op(dfpa_pkg::CMD_MUL, 16'sd0, 15'sd1, 16'sd0, 15'sd1, 0);
        send_op(dfpa_pkg::CMD_MUL, -16'sd2, -15'sd5000, 16'sd3, 15'sd0, 0);
        send_op(dfpa_pkg::CMD_DIV, 16'sd5, 15'sd0, 16'sd0, 15'sd0, 0);
        send_op(dfpa_pkg::CMD_DIV, 16'sd1, 15'sd0, 16'sd3, 15'sd0, 0);
        send_op(dfpa_pkg::CMD_DIV, -16'sd32767, -15'sd9999, 16'sd0, 15'sd1, 1);
        send_op(dfpa_pkg::CMD_DIV, 16'sd0, 15'sd1, -16'sd32767, 15'sd0, 0);
        send_op(dfpa_pkg::CMD_DIV, 16'sd1, -15'sd10000, 16'sd7, 15'sd0, 0);
        send_op(dfpa_pkg::CMD_EQ, 16'sd1, -15'sd10000, 16'sd0, 15'sd0, 0);
        send_op(dfpa_pkg::CMD_EQ, 16'sd2, 15'sd1, 16'sd2, 15'sd2, 0);
        send_op(dfpa_pkg::CMD_GT, 16'sd2, 15'sd2, 16'sd2, 15'sd1, 0);
        send_op(dfpa_pkg::CMD_GT, 16'sh8000, 15'sh4000, 16'sd32767, 15'sd16383, 0);
        send_op(dfpa_pkg::CMD_LT, 16'sh8000, 15'sh4000, 16'sd32767, 15'sd16383, 0);
        send_op(dfpa_pkg::CMD_LT, 16'sd4, 15'sd0, 16'sd4, 15'sd0, 3);
        send_op(CMD_UNUSED, 16'sd9, 15'sd9, 16'sd1, 15'sd1, 0);
        send_op(dfpa_pkg::CMD_ADD, 16'sh8000, 15'sh4000, 16'sh8000, 15'sh4000, 0);

        // hold off until the pipeline has drained
        start = 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        @(negedge clk);

        // random operations with random gaps and back-to-back bursts
        for (int n = 0; n < N_RANDOM; n++)
        begin
            op = ($urandom_range(0, 19) == 0) ? CMD_UNUSED
                                               : dfpa_pkg::CMD_W'($urandom_range(0, 6));
            pick_operand(ai, af);
            pick_operand(bi, bf);
            if (op == dfpa_pkg::CMD_DIV && $urandom_range(0, 9) == 0)
            begin
                bi = '0;
                bf = '0;
            end
            if ((op == dfpa_pkg::CMD_EQ) && $urandom_range(0, 1))
            begin
                bi = ai;
                bf = af;
            end
            gap = ((n / 200) % 2 == 1) ? 0 : $urandom_range(0, 18);
            send_op(op, ai, af, bi, bf, gap);
        end
        start = 1'b0;

        // drain
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
